FILE: sv/vgc_pkg.sv
package vgc_pkg;

    // Alphabet: first symbol sits in the top byte of the literal
    localparam int SYM_COUNT = 75;
    localparam logic [8*SYM_COUNT-1:0] SYMBOLS =
        "qwertyuiopasdfghjklzxcvbnm_,.!():?-+=1234567890%*QWERTYUIOPASDFGHJKLZXCVBNM";

    localparam int IDX_W     = 7;   // alphabet index width
    localparam int KEY_SLOTS = 32;  // key byte slots in the register file
    localparam int POS_W     = 5;   // key position width
    localparam int LEN_W     = 6;   // key length register width

    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_KEY_LEN = 3'd0,
        CFG_KEY_A   = 3'd1,
        CFG_KEY_B   = 3'd2,
        CFG_KEY_C   = 3'd3,
        CFG_KEY_D   = 3'd4
    } t_cfg_idx;

    // Key view handed from the register file to the cipher datapath
    typedef struct packed {
        logic [LEN_W-1:0]              len;    // clamped active length
        logic [KEY_SLOTS-1:0][7:0]     chars;  // byte 0 = first key character
    } t_key_cfg;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_lookup;

    // Symbol at an alphabet index (index below SYM_COUNT)
    function automatic logic [7:0] sym_char(input logic [IDX_W-1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        for (int i = 0; i < SYM_COUNT; i++) begin
            if (idx == IDX_W'(i)) begin
                ch = SYMBOLS[8*(SYM_COUNT-1-i) +: 8];
            end
        end
        return ch;
    endfunction

    // Reverse lookup: alphabet symbols are unique, so at most one match
    function automatic t_lookup sym_lookup(input logic [7:0] ch);
        t_lookup r;
        r = '0;
        for (int i = 0; i < SYM_COUNT; i++) begin
            if (SYMBOLS[8*(SYM_COUNT-1-i) +: 8] == ch) begin
                r.hit = 1'b1;
                r.idx = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/vigenere_cipher_75_symbols.sv
// Vigenere cipher over a 75-symbol alphabet, one byte per request.
// Path: input register, then result register; the key/text lookups and
// modular add or subtract sit between.
// Throughput: 1 request per cycle, limited only by downstream stall.
// Reset (i_rst_n low, synchronous): pipeline empty, cipher state cleared,
// key length 1 and all key characters zero.
module vigenere_cipher_75_symbols
    import vgc_pkg::*;
#(
    parameter int KEY_MAX       = 32,
    parameter int ALPHABET_SIZE = 75
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_char,
    input  logic        i_operation,
    input  logic        i_first_of_message,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_char,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_key_cfg   key_cfg;
    logic       r_a_valid;
    logic [7:0] r_a_char;
    logic       r_a_op;
    logic       r_a_first;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic [7:0] res_char;
    logic       out_free;
    logic       step;
    logic       in_take;

    assign o_cfg_ready = 1'b1;

    // Handshake: result register frees, input stage moves into it
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_a_valid && out_free;
    assign o_in_stall = r_a_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    vgc_cfg_regs #(
        .KEY_MAX (KEY_MAX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key_cfg   (key_cfg)
    );

    vgc_cipher_unit #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_cipher (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_in_char          (r_a_char),
        .i_operation        (r_a_op),
        .i_first_of_message (r_a_first),
        .i_key_cfg          (key_cfg),
        .o_out_char         (res_char)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (step) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_char  <= i_in_char;
            r_a_op    <= i_operation;
            r_a_first <= i_first_of_message;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_char <= res_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;

endmodule

FILE: sv/vgc_cfg_regs.sv
module vgc_cfg_regs
    import vgc_pkg::*;
#(
    parameter int KEY_MAX = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output t_key_cfg    o_key_cfg
);

    logic [LEN_W-1:0] r_key_len;
    logic [63:0]      r_key_a;
    logic [63:0]      r_key_b;
    logic [63:0]      r_key_c;
    logic [63:0]      r_key_d;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= LEN_W'(1);
            r_key_a   <= '0;
            r_key_b   <= '0;
            r_key_c   <= '0;
            r_key_d   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_LEN: r_key_len <= i_cfg_data[LEN_W-1:0];
                CFG_KEY_A:   r_key_a   <= i_cfg_data;
                CFG_KEY_B:   r_key_b   <= i_cfg_data;
                CFG_KEY_C:   r_key_c   <= i_cfg_data;
                CFG_KEY_D:   r_key_d   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Active length: zero acts as one, clamp at KEY_MAX
    always_comb begin
        if (r_key_len == '0) begin
            o_key_cfg.len = LEN_W'(1);
        end else if (r_key_len > LEN_W'(KEY_MAX)) begin
            o_key_cfg.len = LEN_W'(KEY_MAX);
        end else begin
            o_key_cfg.len = r_key_len;
        end
        o_key_cfg.chars = {r_key_d, r_key_c, r_key_b, r_key_a};
    end

endmodule

FILE: sv/vgc_cipher_unit.sv
module vgc_cipher_unit
    import vgc_pkg::*;
#(
    parameter int ALPHABET_SIZE = 75
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_in_char,
    input  logic        i_operation,
    input  logic        i_first_of_message,
    input  t_key_cfg    i_key_cfg,
    output logic [7:0]  o_out_char
);

    localparam int ALPH_N = (ALPHABET_SIZE < SYM_COUNT) ? ALPHABET_SIZE : SYM_COUNT;
    localparam logic [IDX_W:0] N_EXT = (IDX_W+1)'(ALPH_N);

    logic [POS_W-1:0] r_key_pos;
    logic [IDX_W-1:0] r_last_text;
    logic [IDX_W-1:0] r_last_key;

    logic [POS_W-1:0] n_key_pos;
    logic [IDX_W-1:0] n_last_text;
    logic [IDX_W-1:0] n_last_key;

    logic [POS_W-1:0] pos_base;
    logic [POS_W-1:0] pos_use;
    logic [LEN_W-1:0] pos_inc;
    logic [IDX_W-1:0] text_base;
    logic [IDX_W-1:0] key_base;
    logic [7:0]       key_char;
    logic [7:0]       text_char;
    t_lookup          key_lu;
    t_lookup          text_lu;
    logic             key_hit;
    logic             text_hit;
    logic [IDX_W:0]   sum;
    logic [IDX_W:0]   diff;
    logic [IDX_W-1:0] res_idx;
    logic [7:0]       sym;

    // Key, text lookup and modular add/subtract
    always_comb begin
        pos_base  = i_first_of_message ? '0 : r_key_pos;
        text_base = i_first_of_message ? '0 : r_last_text;
        key_base  = i_first_of_message ? '0 : r_last_key;

        pos_use = ({1'b0, pos_base} >= i_key_cfg.len) ? '0 : pos_base;

        key_char = i_key_cfg.chars[pos_use];
        key_lu   = sym_lookup(key_char);
        key_hit  = key_lu.hit && ({1'b0, key_lu.idx} < N_EXT);
        n_last_key = key_hit ? key_lu.idx : key_base;

        // Encrypt maps a space to underscore before lookup
        text_char = (!i_operation && i_in_char == CH_SPACE) ? CH_UNDERSCORE : i_in_char;
        text_lu   = sym_lookup(text_char);
        text_hit  = text_lu.hit && ({1'b0, text_lu.idx} < N_EXT);

        sum  = '0;
        diff = '0;
        if (!i_operation) begin
            n_last_text = text_hit ? text_lu.idx : text_base;
            sum = {1'b0, n_last_text} + {1'b0, n_last_key};
            res_idx = (sum >= N_EXT) ? IDX_W'(sum - N_EXT) : sum[IDX_W-1:0];
        end else begin
            diff = {1'b0, text_lu.idx} - {1'b0, n_last_key};
            if (text_hit) begin
                n_last_text = diff[IDX_W] ? IDX_W'(diff + N_EXT) : diff[IDX_W-1:0];
            end else begin
                n_last_text = text_base;
            end
            res_idx = n_last_text;
        end

        sym = sym_char(res_idx);
        o_out_char = (i_operation && sym == CH_UNDERSCORE) ? CH_SPACE : sym;

        pos_inc   = {1'b0, pos_use} + LEN_W'(1);
        n_key_pos = (pos_inc >= i_key_cfg.len) ? '0 : pos_inc[POS_W-1:0];
    end

    // Running cipher state, updated once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos   <= '0;
            r_last_text <= '0;
            r_last_key  <= '0;
        end else if (i_step) begin
            r_key_pos   <= n_key_pos;
            r_last_text <= n_last_text;
            r_last_key  <= n_last_key;
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb
    import vgc_pkg::*;
;

    localparam int RANDOM_REQUESTS = 1350;
    localparam int HOLD_CYCLES     = 150;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LIMIT_CYCLES    = 600000;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_char;
    logic        i_operation;
    logic        i_first_of_message;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_char;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    // Cipher predictor plus the queue of output bytes still owed by the block
    class cipher_scoreboard;
        logic [7:0]       glyph[SYM_COUNT];
        int               slot_of[256];
        logic [LEN_W-1:0] key_len;
        logic [63:0]      key_word[4];
        logic [POS_W-1:0] key_pos;
        logic [IDX_W-1:0] text_idx;
        logic [IDX_W-1:0] key_idx;
        logic [7:0]       expected_chars[$];
        int               errors;
        int               checked;

        function new();
            for (int c = 0; c < 256; c++) begin
                slot_of[c] = -1;
            end
            for (int i = 0; i < SYM_COUNT; i++) begin
                glyph[i] = SYMBOLS[8*(SYM_COUNT-1-i) +: 8];
                slot_of[glyph[i]] = i;
            end
            key_len  = 1;
            for (int w = 0; w < 4; w++) begin
                key_word[w] = '0;
            end
            key_pos  = '0;
            text_idx = '0;
            key_idx  = '0;
            errors   = 0;
            checked  = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [63:0] data);
            case (idx)
                CFG_KEY_LEN: key_len = data[LEN_W-1:0];
                CFG_KEY_A:   key_word[0] = data;
                CFG_KEY_B:   key_word[1] = data;
                CFG_KEY_C:   key_word[2] = data;
                CFG_KEY_D:   key_word[3] = data;
                default: ;
            endcase
        endfunction

        // Advance the cipher state by one accepted request, queue its output byte
        function void note_request(logic [7:0] ch, logic decrypt, logic first);
            int         span;
            int         slot;
            int         res;
            logic [7:0] kch;
            logic [7:0] sym;
            span = (key_len == 0) ? 1 : (key_len > KEY_SLOTS) ? KEY_SLOTS : int'(key_len);
            if (first) begin
                key_pos  = '0;
                text_idx = '0;
                key_idx  = '0;
            end
            if (key_pos >= span) key_pos = '0;

            // key byte not in the alphabet keeps the previous key index
            kch = key_word[key_pos[4:3]][8*key_pos[2:0] +: 8];
            if (slot_of[kch] >= 0) key_idx = IDX_W'(slot_of[kch]);

            if (decrypt == OP_ENCRYPT) begin
                slot = slot_of[(ch == CH_SPACE) ? CH_UNDERSCORE : ch];
                if (slot >= 0) text_idx = IDX_W'(slot);
                res = (text_idx + key_idx) % SYM_COUNT;
            end else begin
                // unknown cipher byte repeats the previous plain index
                slot = slot_of[ch];
                if (slot >= 0) text_idx = IDX_W'((slot + SYM_COUNT - key_idx) % SYM_COUNT);
                res = text_idx;
            end

            sym = glyph[res];
            if (decrypt == OP_DECRYPT && sym == CH_UNDERSCORE) sym = CH_SPACE;
            key_pos = (key_pos + 1 >= span) ? '0 : key_pos + 1'b1;
            expected_chars.insert(expected_chars.size(), sym);
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] want;
            if (expected_chars.size() == 0) begin
                $display("%0t: out_char expected none actual %02h", $time, got);
                errors++;
            end else begin
                want = expected_chars.pop_front();
                checked++;
                if (got !== want) begin
                    $display("%0t: out_char expected %02h actual %02h", $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    cipher_scoreboard sb;
    bit steady;     // no idling on either side while set
    bit hold_req;   // asks the result side for one long hold-off
    int sent;
    int directed_count;
    int key_setups;
    int cycles;

    vigenere_cipher_75_symbols u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_char          (i_in_char),
        .i_operation        (i_operation),
        .i_first_of_message (i_first_of_message),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_char         (o_out_char),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Message bytes: mostly alphabet symbols, some spaces and underscores, some noise
    function automatic logic [7:0] pick_text();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return sb.glyph[$urandom_range(0, SYM_COUNT-1)];
        if (r < 80) return CH_SPACE;
        if (r < 85) return CH_UNDERSCORE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [63:0] random_key_word(int alpha_pct);
        logic [63:0] w;
        for (int b = 0; b < 8; b++) begin
            w[8*b +: 8] = ($urandom_range(0, 99) < alpha_pct) ?
                          sb.glyph[$urandom_range(0, SYM_COUNT-1)] : 8'($urandom_range(0, 255));
        end
        return w;
    endfunction

    task automatic send_request(logic [7:0] ch, logic decrypt, logic first);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_in_char          <= ch;
        i_operation        <= decrypt;
        i_first_of_message <= first;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(ch, decrypt, first);
        sent++;
    endtask

    // Stop offering and wait until every owed result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // Full key setup while the block is idle; junk above the length field
    task automatic load_key(logic [5:0] len, logic [63:0] w0, logic [63:0] w1,
                            logic [63:0] w2, logic [63:0] w3);
        drain_results();
        cfg_write(CFG_KEY_LEN, {58'({$urandom(), $urandom()}), len});
        cfg_write(CFG_KEY_A, w0);
        cfg_write(CFG_KEY_B, w1);
        cfg_write(CFG_KEY_C, w2);
        cfg_write(CFG_KEY_D, w3);
        i_cfg_valid <= 1'b0;
        key_setups++;
    endtask

    // One message: first byte restarts the key, a few broken ones scatter restarts
    task automatic send_message(int len);
        logic decrypt;
        bit   broken;
        decrypt = 1'($urandom_range(0, 1));
        broken  = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++) begin
            send_request(pick_text(),
                         ($urandom_range(0, 9) == 0) ? ~decrypt : decrypt,
                         broken ? ($urandom_range(0, 3) == 0) : (k == 0));
        end
        if ($urandom_range(0, 19) == 0) drain_results();
    endtask

    // Result side stall pattern, with one long hold-off on request
    initial begin : stall_drive
        int run_left;
        bit held;
        run_left = 0;
        held     = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                run_left = 0;
            end else if (steady) begin
                i_out_stall <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    held     = ($urandom_range(0, 99) < 30);
                    run_left = held ? 1 + idle_len() : $urandom_range(1, 10);
                end
                i_out_stall <= held;
                run_left--;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_char);
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results owed", cycles, sb.pending());
        $display("FAIL vigenere_cipher_75_symbols");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int phase_end;
        sb         = new();
        steady     = 1'b0;
        hold_req   = 1'b0;
        sent       = 0;
        key_setups = 0;
        i_rst_n            <= 1'b0;
        i_in_valid         <= 1'b0;
        i_in_char          <= 8'h00;
        i_operation        <= OP_ENCRYPT;
        i_first_of_message <= 1'b0;
        i_cfg_valid        <= 1'b0;
        i_cfg_index        <= CFG_KEY_LEN;
        i_cfg_data         <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset key: all zero bytes, none of them in the alphabet
        send_request("q", OP_ENCRYPT, 1'b1);
        send_request(8'hFF, OP_ENCRYPT, 1'b0);
        send_request("M", OP_DECRYPT, 1'b0);

        // Key of last symbol, first symbol, then a byte outside the alphabet
        load_key(6'd3, {40'h0, 8'h01, "q", "M"}, '0, '0, '0);
        send_request("q", OP_ENCRYPT, 1'b1);
        send_request(CH_SPACE, OP_ENCRYPT, 1'b0);
        send_request(8'hFF, OP_ENCRYPT, 1'b0);
        send_request("M", OP_ENCRYPT, 1'b0);
        send_request(CH_UNDERSCORE, OP_DECRYPT, 1'b0);
        send_request("q", OP_DECRYPT, 1'b1);
        send_request(CH_UNDERSCORE, OP_DECRYPT, 1'b0);
        send_request(8'h00, OP_DECRYPT, 1'b0);
        send_request(CH_SPACE, OP_DECRYPT, 1'b0);
        send_request(8'h80, OP_ENCRYPT, 1'b1);

        // Zero length behaves as one
        load_key(6'd0, random_key_word(100), '0, '0, '0);
        send_request("w", OP_ENCRYPT, 1'b1);
        send_request("N", OP_DECRYPT, 1'b0);
        send_request(8'h7F, OP_ENCRYPT, 1'b0);

        // Length above the slot count clamps to the full key
        load_key(6'd63, random_key_word(90), random_key_word(90),
                 random_key_word(90), random_key_word(90));
        send_request("%", OP_ENCRYPT, 1'b1);
        send_request("=", OP_DECRYPT, 1'b0);
        send_request(CH_SPACE, OP_ENCRYPT, 1'b0);
        send_request(8'h5E, OP_DECRYPT, 1'b0);
        directed_count = sent;

        // Random phases, each under its own key
        phase = 0;
        while (sent - directed_count < RANDOM_REQUESTS) begin
            case (phase % 8)
                0: load_key(6'd32, random_key_word(90), random_key_word(90),
                            random_key_word(90), random_key_word(90));
                1: load_key(6'd1, random_key_word(90), random_key_word(90),
                            random_key_word(90), random_key_word(90));
                3: load_key(6'd0, random_key_word(80), random_key_word(80),
                            random_key_word(80), random_key_word(80));
                4: load_key(6'd63, '1, '1, '1, '1);
                5: load_key(6'($urandom_range(2, 31)), '0, '0, '0, '0);
                6: load_key(6'd32, random_key_word(60), random_key_word(60),
                            random_key_word(60), random_key_word(60));
                default: load_key(6'($urandom_range(1, 32)), random_key_word(85),
                                  random_key_word(85), random_key_word(85),
                                  random_key_word(85));
            endcase

            // Back-pressure: results held off while requests keep coming
            if (phase % 8 == 2) begin
                hold_req = 1'b1;
                steady   = 1'b1;
                send_message(60);
                steady   = 1'b0;
            end
            // A stretch with no idling on either side
            if (phase % 8 == 4) begin
                steady = 1'b1;
                send_message(60);
                steady = 1'b0;
            end

            phase_end = sent + 170;
            while (sent < phase_end && sent - directed_count < RANDOM_REQUESTS) begin
                send_message(($urandom_range(0, 9) == 0) ? $urandom_range(33, 64)
                                                         : $urandom_range(1, 20));
            end
            phase++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end

        $display("Sent %0d requests (%0d directed) under %0d key setups, %0d results checked",
                 sent, directed_count, key_setups, sb.checked);
        $display("Both directions, key lengths 0 to 63, off-alphabet bytes, long back-pressure");
        if (sb.errors == 0) begin
            $display("PASS vigenere_cipher_75_symbols");
        end else begin
            $display("FAIL vigenere_cipher_75_symbols");
        end
        $finish;
    end

endmodule
